>>> sv/mbe_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the escape-time engine.
// No dependencies; every other file but mbe_fifo imports this package.
package mbe_pkg;

    localparam int COORD_W    = 48;
    localparam int STEP_W     = 47;
    localparam int ITER_W     = 12;
    localparam int IDX_W      = 10;
    localparam int PROD_W     = IDX_W + STEP_W;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_ADDR_W-1:0] REG_X_LEFT   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_Y_BOTTOM = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_STEP_X   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_STEP_Y   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_ITER = 3'd4;

    localparam logic [ITER_W-1:0] MAX_ITER_RST = 12'd500;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_left;
        logic signed [COORD_W-1:0] y_bottom;
        logic [STEP_W-1:0]         step_x;
        logic [STEP_W-1:0]         step_y;
    } cfg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] cr;
        logic signed [COORD_W-1:0] ci;
    } point_t;

endpackage

>>> sv/mbe_fifo.sv
`timescale 1ns / 1ps
// Two-entry register queue, used between front and back and for results.
// Depends on nothing.
module mbe_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    logic [1:0]       cnt_reg;
    logic [1:0]       cnt_next;
    logic [WIDTH-1:0] e0_reg;
    logic [WIDTH-1:0] e1_reg;
    logic             do_push;
    logic             do_pop;
    logic [1:0]       widx;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign dout    = e0_reg;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign widx    = cnt_reg - {1'b0, do_pop};

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_pop)
        begin
            e0_reg <= e1_reg;
        end
        if (do_push && widx == 2'd0)
        begin
            e0_reg <= din;
        end
        if (do_push && widx == 2'd1)
        begin
            e1_reg <= din;
        end
    end

endmodule

>>> sv/mbe_front.sv
`timescale 1ns / 1ps
// Front end: takes pixel indices, clamps them and forms the point c.
// Depends on mbe_pkg.
module mbe_front
    import mbe_pkg::*;
#(
    parameter int COLS = 1024,
    parameter int ROWS = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [IDX_W-1:0] col,
    input  logic [IDX_W-1:0] row,
    input  cfg_t             cfg,
    input  logic             q_full,
    output logic             q_push,
    output point_t           q_pt
);

    localparam int SUM_W = PROD_W + 2;

    logic              adv;
    logic              accept;
    logic [IDX_W-1:0]  col_c;
    logic [IDX_W-1:0]  row_c;
    logic              s1_valid_reg;
    logic              s2_valid_reg;
    logic [PROD_W-1:0] px_reg;
    logic [PROD_W-1:0] py_reg;
    point_t            pt_reg;
    point_t            pt_next;

    // origin plus a nonnegative offset can only overflow upward
    function automatic logic signed [COORD_W-1:0] sat_add(
        input logic signed [COORD_W-1:0] base,
        input logic [PROD_W-1:0]         off
    );
        logic signed [SUM_W-1:0] s;
        s = SUM_W'(base) + $signed({2'b00, off});
        if (!s[SUM_W-1] && (|s[SUM_W-2:COORD_W-1]))
        begin
            return {1'b0, {(COORD_W-1){1'b1}}};
        end
        return s[COORD_W-1:0];
    endfunction

    assign adv    = !s2_valid_reg || !q_full;
    assign full   = !adv;
    assign accept = push && adv;
    assign q_push = s2_valid_reg && !q_full;
    assign q_pt   = pt_reg;

    always_comb
    begin
        col_c = col;
        row_c = row;
        if (32'(col) >= COLS)
        begin
            col_c = IDX_W'(COLS - 1);
        end
        if (32'(row) >= ROWS)
        begin
            row_c = IDX_W'(ROWS - 1);
        end
        pt_next.cr = sat_add(cfg.x_left, px_reg);
        pt_next.ci = sat_add(cfg.y_bottom, py_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg <= PROD_W'(col_c) * PROD_W'(cfg.step_x);
            py_reg <= PROD_W'(row_c) * PROD_W'(cfg.step_y);
            pt_reg <= pt_next;
        end
    end

endmodule

>>> sv/mbe_iter.sv
`timescale 1ns / 1ps
// Back end: iterates z = z*z + c for one point at a time, each pass running through the step, multiply and sum states.
// Depends on mbe_pkg.
module mbe_iter
    import mbe_pkg::*;
#(
    parameter int FRAC_BITS = 43
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pt_valid,
    input  point_t            pt,
    output logic              pt_pop,
    input  logic [ITER_W-1:0] max_iter,
    input  logic              res_full,
    output logic              res_push,
    output logic [ITER_W-1:0] res_count
);

    // |z| <= 2.0 once a pass survives, so magnitudes fit in MW bits
    localparam int MW = FRAC_BITS + 2;
    localparam int H  = (MW + 1) / 2;
    localparam int HH = MW - H;
    localparam int PW = 2 * MW;
    localparam int SW = FRAC_BITS + 3;
    localparam int XW = FRAC_BITS + 5;
    localparam int AW = ((XW > COORD_W) ? XW : COORD_W) + 2;

    localparam logic [AW-1:0] TWO =
        {{(AW - FRAC_BITS - 2){1'b0}}, 2'b10, {FRAC_BITS{1'b0}}};
    localparam logic [SW:0] FOUR = {1'b0, 3'b100, {FRAC_BITS{1'b0}}};

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_STEP = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_SUM  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]                state_reg;
    logic [2:0]                state_next;
    logic [ITER_W-1:0]         cnt_reg;
    logic [ITER_W-1:0]         cnt_next;
    logic signed [COORD_W-1:0] cr_reg;
    logic signed [COORD_W-1:0] ci_reg;
    logic [SW-1:0]             sr_reg;
    logic [SW-1:0]             si_reg;
    logic signed [XW-1:0]      x_reg;
    logic [MW-1:0]             mr_reg;
    logic [MW-1:0]             mi_reg;
    logic                      neg_reg;

    logic [2*H-1:0]            rll_reg;
    logic [H+HH-1:0]           rlh_reg;
    logic [2*HH-1:0]           rhh_reg;
    logic [2*H-1:0]            ill_reg;
    logic [H+HH-1:0]           ilh_reg;
    logic [2*HH-1:0]           ihh_reg;
    logic [2*H-1:0]            xll_reg;
    logic [H+HH-1:0]           xlh_reg;
    logic [H+HH-1:0]           xhl_reg;
    logic [2*HH-1:0]           xhh_reg;

    logic signed [AW-1:0]      nr;
    logic signed [AW-1:0]      ni;
    logic [AW-1:0]             ar;
    logic [AW-1:0]             ai;
    logic                      esc_mag;
    logic [H-1:0]              r_lo;
    logic [HH-1:0]             r_hi;
    logic [H-1:0]              i_lo;
    logic [HH-1:0]             i_hi;
    logic [PW-1:0]             pr;
    logic [PW-1:0]             pi;
    logic [PW-1:0]             px;
    logic signed [PW:0]        pxs;
    logic signed [PW:0]        xs;
    logic [SW-1:0]             sr_next;
    logic [SW-1:0]             si_next;
    logic [SW:0]               mag2;
    logic                      esc_sq;

    // next z from the squares and cross term of the current z
    always_comb
    begin
        nr = AW'($signed({1'b0, sr_reg})) - AW'($signed({1'b0, si_reg})) + AW'(cr_reg);
        ni = AW'(x_reg) + AW'(ci_reg);
        ar = nr[AW-1] ? (~nr + 1'b1) : nr;
        ai = ni[AW-1] ? (~ni + 1'b1) : ni;
        esc_mag = (ar > TWO) || (ai > TWO);
    end

    assign r_lo = mr_reg[H-1:0];
    assign r_hi = mr_reg[MW-1:H];
    assign i_lo = mi_reg[H-1:0];
    assign i_hi = mi_reg[MW-1:H];

    // recombine the partial products; shifts floor toward minus infinity
    always_comb
    begin
        pr = (PW'(rhh_reg) << (2 * H)) + (PW'(rlh_reg) << (H + 1)) + PW'(rll_reg);
        pi = (PW'(ihh_reg) << (2 * H)) + (PW'(ilh_reg) << (H + 1)) + PW'(ill_reg);
        px = (PW'(xhh_reg) << (2 * H)) + (PW'(xlh_reg) << H) + (PW'(xhl_reg) << H)
            + PW'(xll_reg);
        pxs = neg_reg ? -$signed({1'b0, px}) : $signed({1'b0, px});
        xs = pxs >>> (FRAC_BITS - 1);
        sr_next = pr[FRAC_BITS +: SW];
        si_next = pi[FRAC_BITS +: SW];
        mag2 = {1'b0, sr_next} + {1'b0, si_next};
        esc_sq = mag2 > FOUR;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pt_pop     = 1'b0;
        res_push   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pt_valid)
                begin
                    pt_pop     = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (cnt_reg == max_iter || esc_mag)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                if (esc_sq)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_STEP;
                end
            end
            ST_OUT:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res_count = cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE)
        begin
            cr_reg <= pt.cr;
            ci_reg <= pt.ci;
            sr_reg <= '0;
            si_reg <= '0;
            x_reg  <= '0;
        end
        if (state_reg == ST_STEP)
        begin
            mr_reg  <= ar[MW-1:0];
            mi_reg  <= ai[MW-1:0];
            neg_reg <= nr[AW-1] ^ ni[AW-1];
        end
        if (state_reg == ST_MUL)
        begin
            rll_reg <= {{H{1'b0}}, r_lo} * {{H{1'b0}}, r_lo};
            rlh_reg <= {{HH{1'b0}}, r_lo} * {{H{1'b0}}, r_hi};
            rhh_reg <= {{HH{1'b0}}, r_hi} * {{HH{1'b0}}, r_hi};
            ill_reg <= {{H{1'b0}}, i_lo} * {{H{1'b0}}, i_lo};
            ilh_reg <= {{HH{1'b0}}, i_lo} * {{H{1'b0}}, i_hi};
            ihh_reg <= {{HH{1'b0}}, i_hi} * {{HH{1'b0}}, i_hi};
            xll_reg <= {{H{1'b0}}, r_lo} * {{H{1'b0}}, i_lo};
            xlh_reg <= {{HH{1'b0}}, r_lo} * {{H{1'b0}}, i_hi};
            xhl_reg <= {{H{1'b0}}, r_hi} * {{HH{1'b0}}, i_lo};
            xhh_reg <= {{HH{1'b0}}, r_hi} * {{HH{1'b0}}, i_hi};
        end
        if (state_reg == ST_SUM)
        begin
            sr_reg <= sr_next;
            si_reg <= si_next;
            x_reg  <= xs[XW-1:0];
        end
    end

endmodule

>>> sv/mandelbrot_escape_time.sv
`timescale 1ns / 1ps
// Escape-time engine: one pixel index pair in, one iteration count out, both
// as queues. The front end clamps the indices, forms c through its product and
// point registers and hands it through a two-entry queue to the iteration loop,
// so it can take the next pixel while the loop is busy. Each pass of the loop
// runs z = z*z + c as add and bound check, partial products of the 23- and
// 22-bit halves, then recombine and |z|^2 check. The iteration limit resets
// to 500. Results wait in a two-entry output queue.
// Depends on mbe_pkg, mbe_front, mbe_fifo, mbe_iter.
module mandelbrot_escape_time
    import mbe_pkg::*;
#(
    parameter int COLS      = 1024,
    parameter int ROWS      = 1024,
    parameter int FRAC_BITS = 43
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [IDX_W-1:0]      col,
    input  logic [IDX_W-1:0]      row,
    output logic                  empty,
    input  logic                  pop,
    output logic [ITER_W-1:0]     iter_count,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t              cfg_reg;
    logic [ITER_W-1:0] max_iter_reg;
    logic              cq_full;
    logic              cq_push;
    point_t            cq_din;
    point_t            cq_dout;
    logic              cq_empty;
    logic              cq_pop;
    logic              rq_full;
    logic              rq_push;
    logic [ITER_W-1:0] rq_din;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg      <= '0;
            max_iter_reg <= MAX_ITER_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_X_LEFT:   cfg_reg.x_left   <= cfg_wdata[COORD_W-1:0];
                REG_Y_BOTTOM: cfg_reg.y_bottom <= cfg_wdata[COORD_W-1:0];
                REG_STEP_X:   cfg_reg.step_x   <= cfg_wdata[STEP_W-1:0];
                REG_STEP_Y:   cfg_reg.step_y   <= cfg_wdata[STEP_W-1:0];
                REG_MAX_ITER: max_iter_reg     <= cfg_wdata[ITER_W-1:0];
                default:      ;
            endcase
        end
    end

    mbe_front #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .col    (col),
        .row    (row),
        .cfg    (cfg_reg),
        .q_full (cq_full),
        .q_push (cq_push),
        .q_pt   (cq_din)
    );

    mbe_fifo #(
        .WIDTH ($bits(point_t))
    ) u_cq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cq_push),
        .din   (cq_din),
        .full  (cq_full),
        .pop   (cq_pop),
        .dout  (cq_dout),
        .empty (cq_empty)
    );

    mbe_iter #(
        .FRAC_BITS (FRAC_BITS)
    ) u_iter (
        .clk       (clk),
        .rst_n     (rst_n),
        .pt_valid  (!cq_empty),
        .pt        (cq_dout),
        .pt_pop    (cq_pop),
        .max_iter  (max_iter_reg),
        .res_full  (rq_full),
        .res_push  (rq_push),
        .res_count (rq_din)
    );

    mbe_fifo #(
        .WIDTH (ITER_W)
    ) u_rq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (rq_push),
        .din   (rq_din),
        .full  (rq_full),
        .pop   (pop),
        .dout  (iter_count),
        .empty (empty)
    );

endmodule

>>> sv/mbe_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the escape-time engine, bound to the top level.
// Depends on mbe_pkg.
module mbe_chk
    import mbe_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  push,
    input logic                  full,
    input logic                  empty,
    input logic                  pop,
    input logic [ITER_W-1:0]     iter_count,
    input logic                  cfg_we,
    input logic [CFG_ADDR_W-1:0] cfg_addr,
    input logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [3:0]        outst_reg;
    logic [3:0]        outst_next;
    logic [ITER_W-1:0] lim_reg;
    logic              in_xfer;
    logic              out_xfer;

    assign in_xfer  = push && !full;
    assign out_xfer = pop && !empty;

    always_comb
    begin
        outst_next = outst_reg;
        if (in_xfer && !out_xfer)
        begin
            outst_next = outst_reg + 4'd1;
        end
        else if (out_xfer && !in_xfer)
        begin
            outst_next = outst_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outst_reg <= '0;
            lim_reg   <= MAX_ITER_RST;
        end
        else
        begin
            outst_reg <= outst_next;
            if (cfg_we && cfg_addr == REG_MAX_ITER)
            begin
                lim_reg <= cfg_wdata[ITER_W-1:0];
            end
        end
    end

    // the first edge in reset may still see the pre-reset count
    a_empty_in_reset: assert property (@(posedge clk) (!rst_n ##1 !rst_n) |-> empty)
        else $error("result queue not empty during reset");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(iter_count)))
        else $error("waiting result changed before transfer");

    a_count_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (iter_count <= lim_reg))
        else $error("iteration count above limit");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (outst_reg != 4'd0))
        else $error("result shown with no pixel outstanding");

    a_full_needs_work: assert property (@(posedge clk) disable iff (!rst_n)
        (outst_reg == 4'd0) |-> !full)
        else $error("full raised while engine holds no pixel");

endmodule

bind mandelbrot_escape_time mbe_chk u_chk (.*);
